// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, quiet while reset is held.
`define ASSERT_CLK(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) else $error(msg);

// Check that one condition implies another on the same clock edge.
`define ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk_s, rst_n, (ante) |-> (cons), msg)

`endif

// ===== sv/tva_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tva_pkg: shared types and constants for the triangle vertex angle unit
// Widths, special angles, case codes and the arctangent table.
// ---------------------------------------------------------------------------
package tva_pkg;

	localparam int COORD_W    = 32;
	localparam int MAG_W      = 32;
	localparam int SQ_W       = 64;
	localparam int SUM_W      = 66;
	localparam int ROOT_W     = 36;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int HALF_W     = ROOT_W / 2;
	localparam int EPS_W      = 16;
	localparam int CX_W       = 48;
	localparam int CZ_W       = 33;
	localparam int ANGLE_W    = 18;
	localparam int SHIFT_W    = 6;
	localparam int NORM_MSB   = 40;
	localparam int ROUND_SH   = 13;
	localparam int ATAN_STEPS = 18;
	localparam int TAB_W      = 30;

	localparam logic [EPS_W-1:0]   EPS_RESET  = 16'd66;
	localparam logic [ANGLE_W-1:0] ANGLE_PI   = 18'd205887;
	localparam logic [ANGLE_W-1:0] ANGLE_PI_3 = 18'd68629;

	typedef enum logic [1:0] {
		CASE_NORMAL    = 2'd0,
		CASE_COLLAPSED = 2'd1,
		CASE_FLAT      = 2'd2
	} case_t;

	// atan(2^-i) in Q2.30, indexed by the low five bits of the step number
	function automatic logic [TAB_W-1:0] atan_tab(input logic [4:0] idx);
		logic [TAB_W-1:0] t;
		case (idx)
			5'd0:  t = 30'd843314857;
			5'd1:  t = 30'd497837829;
			5'd2:  t = 30'd263043837;
			5'd3:  t = 30'd133525159;
			5'd4:  t = 30'd67021687;
			5'd5:  t = 30'd33543516;
			5'd6:  t = 30'd16775851;
			5'd7:  t = 30'd8388437;
			5'd8:  t = 30'd4194283;
			5'd9:  t = 30'd2097149;
			5'd10: t = 30'd1048576;
			5'd11: t = 30'd524288;
			5'd12: t = 30'd262144;
			5'd13: t = 30'd131072;
			5'd14: t = 30'd65536;
			5'd15: t = 30'd32768;
			5'd16: t = 30'd16384;
			5'd17: t = 30'd8192;
			5'd18: t = 30'd4096;
			5'd19: t = 30'd2048;
			5'd20: t = 30'd1024;
			5'd21: t = 30'd512;
			5'd22: t = 30'd256;
			5'd23: t = 30'd128;
			5'd24: t = 30'd64;
			5'd25: t = 30'd32;
			5'd26: t = 30'd16;
			5'd27: t = 30'd8;
			5'd28: t = 30'd4;
			5'd29: t = 30'd2;
			5'd30: t = 30'd1;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/tva_isqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tva_isqrt: pipelined floor square root, several lanes side by side
// One root bit per register stage, restoring form with a running residual.
// ---------------------------------------------------------------------------
module tva_isqrt #(
	parameter int LANES  = 1,
	parameter int ROOT_W = tva_pkg::ROOT_W
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2*ROOT_W-1:0]   rad  [LANES],
	output logic [ROOT_W-1:0]     root [LANES]
);

	localparam int RW = 2 * ROOT_W;

	logic [RW-1:0]     rem_q [ROOT_W][LANES];
	logic [ROOT_W-1:0] rt_q  [ROOT_W][LANES];

	genvar j;
	generate
		for (j = 0; j < ROOT_W; j++) begin : g_stage
			localparam int B = ROOT_W - 1 - j;
			logic [RW-1:0]     d_in  [LANES];
			logic [ROOT_W-1:0] r_in  [LANES];
			logic [RW-1:0]     d_nx  [LANES];
			logic [ROOT_W-1:0] r_nx  [LANES];

			always_comb begin
				logic [RW-1:0] trial;
				for (int l = 0; l < LANES; l++) begin
					if (j == 0) begin
						d_in[l] = rad[l];
						r_in[l] = '0;
					end else begin
						d_in[l] = rem_q[(j == 0) ? 0 : j-1][l];
						r_in[l] = rt_q[(j == 0) ? 0 : j-1][l];
					end
					// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
					trial = (RW'(r_in[l]) << (B + 1)) | (RW'(1) << (2 * B));
					if (trial <= d_in[l]) begin
						d_nx[l] = d_in[l] - trial;
						r_nx[l] = r_in[l] | (ROOT_W'(1) << B);
					end else begin
						d_nx[l] = d_in[l];
						r_nx[l] = r_in[l];
					end
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= d_nx;
					rt_q[j]  <= r_nx;
				end
			end
		end
	endgenerate

	assign root = rt_q[ROOT_W-1];

endmodule

// ===== sv/triangle_vertex_angle_3d_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle_vertex_angle_3d_unit: interior angle at a vertex of a 3D triangle
// Side lengths by square root, half-angle formula, CORDIC arctangent.
// ---------------------------------------------------------------------------
// Takes one point triple (signed Q16.16) per cycle while the pipeline is not
// stalled and returns the interior angle at the first point in unsigned Q2.16
// radians, with a case code on m_tuser (normal, collapsed triangle giving pi/3,
// flat triangle giving pi). The unit is a single stalling pipeline: a new word
// enters on every cycle in which the output register is empty or being taken.
// Most of its depth lies in the two bit-per-stage square root pipelines (36
// stages each) and in the CORDIC, one rotation per stage. epsilon is written
// through cfg_we and cfg_wdata and should only change while no word is in
// flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_vertex_angle_3d_unit #(
	parameter int ATAN_STEPS = tva_pkg::ATAN_STEPS
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: epsilon
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// vertex_x, vertex_y, vertex_z, second_x, second_y, second_z,
	// third_x, third_y, third_z (32 bits each, from bit 0 up)
	input  logic [287:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// angle [17:0], zero fill above
	output logic [23:0]  m_tdata,
	// case_code [1:0]
	output logic [1:0]   m_tuser
);

	localparam int ROOT_W = tva_pkg::ROOT_W;
	localparam int RAD_W  = tva_pkg::RAD_W;
	localparam int HALF_W = tva_pkg::HALF_W;
	localparam int CX_W   = tva_pkg::CX_W;
	localparam int CZ_W   = tva_pkg::CZ_W;

	// Global advance: every stage moves when the output register can take a word.
	logic adv;
	logic out_vld_q;
	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;

	// Epsilon register
	logic [tva_pkg::EPS_W-1:0] eps_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= tva_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------- s1
	// Unpack the nine coordinates and form absolute differences.
	// Side a: third - second, b: vertex - third, c: second - vertex.
	logic signed [tva_pkg::COORD_W-1:0] crd [9];
	logic [tva_pkg::MAG_W-1:0]          mag_s1 [3][3];
	logic                               vld_s1;

	always_comb begin
		for (int n = 0; n < 9; n++) begin
			crd[n] = s_tdata[n*tva_pkg::COORD_W +: tva_pkg::COORD_W];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [tva_pkg::COORD_W:0] d;
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				d = 33'(crd[6+k]) - 33'(crd[3+k]);
				mag_s1[0][k] <= d[32] ? 32'(-d) : d[31:0];
				d = 33'(crd[k]) - 33'(crd[6+k]);
				mag_s1[1][k] <= d[32] ? 32'(-d) : d[31:0];
				d = 33'(crd[3+k]) - 33'(crd[k]);
				mag_s1[2][k] <= d[32] ? 32'(-d) : d[31:0];
			end
		end
	end

	// ---------------------------------------------------------------- s2
	logic [tva_pkg::SQ_W-1:0] sq_s2 [3][3];
	logic                     vld_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s < 3; s++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s2[s][k] <= 64'(mag_s1[s][k]) * 64'(mag_s1[s][k]);
				end
			end
		end
	end

	// ---------------------------------------------------------------- s3
	logic [RAD_W-1:0] rad1_s3 [3];
	logic             vld_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s < 3; s++) begin
				rad1_s3[s] <= RAD_W'(tva_pkg::SUM_W'(sq_s2[s][0])
					+ tva_pkg::SUM_W'(sq_s2[s][1]) + tva_pkg::SUM_W'(sq_s2[s][2]));
			end
		end
	end

	// Side lengths a, b, c
	logic [ROOT_W-1:0] side [3];
	logic              vld_r1 [ROOT_W];

	tva_isqrt #(.LANES(3), .ROOT_W(ROOT_W)) u_sides (
		.clk  (clk),
		.en   (adv),
		.rad  (rad1_s3),
		.root (side)
	);

	// ---------------------------------------------------------------- s4
	// Half-perimeter tests and factors of the quotient, X and Y clamped at zero.
	logic [ROOT_W-1:0]      p_s4, z_s4, x_s4, y_s4;
	tva_pkg::case_t         case_s4;
	logic                   vld_s4;
	logic [ROOT_W-1:0]      p_sum;
	logic signed [ROOT_W:0] z_d, x_d, y_d, e2;

	always_comb begin
		p_sum = side[0] + side[1] + side[2];
		e2    = (ROOT_W+1)'({eps_q, 1'b0});
		z_d   = $signed({1'b0, p_sum}) - $signed({side[0], 1'b0});
		x_d   = $signed({1'b0, p_sum}) - $signed({side[1], 1'b0});
		y_d   = $signed({1'b0, p_sum}) - $signed({side[2], 1'b0});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4 <= p_sum;
			z_s4 <= z_d[ROOT_W-1:0];
			x_s4 <= x_d[ROOT_W] ? '0 : x_d[ROOT_W-1:0];
			y_s4 <= y_d[ROOT_W] ? '0 : y_d[ROOT_W-1:0];
			if ($signed({1'b0, p_sum}) <= e2) begin
				case_s4 <= tva_pkg::CASE_COLLAPSED;
			end else if (z_d <= e2) begin
				case_s4 <= tva_pkg::CASE_FLAT;
			end else begin
				case_s4 <= tva_pkg::CASE_NORMAL;
			end
		end
	end

	// ---------------------------------------------------------------- s5
	// 18x18 partial products of X*Y (lane 0) and P*Z (lane 1).
	logic [ROOT_W-1:0] pp_s5 [2][4];
	tva_pkg::case_t    case_s5;
	logic              vld_s5;
	always_ff @(posedge clk) begin
		logic [ROOT_W-1:0] opa [2];
		logic [ROOT_W-1:0] opb [2];
		opa[0] = x_s4;
		opb[0] = y_s4;
		opa[1] = p_s4;
		opb[1] = z_s4;
		if (adv) begin
			case_s5 <= case_s4;
			for (int l = 0; l < 2; l++) begin
				pp_s5[l][0] <= ROOT_W'(opa[l][HALF_W-1:0]) * ROOT_W'(opb[l][HALF_W-1:0]);
				pp_s5[l][1] <= ROOT_W'(opa[l][ROOT_W-1:HALF_W]) * ROOT_W'(opb[l][HALF_W-1:0]);
				pp_s5[l][2] <= ROOT_W'(opa[l][HALF_W-1:0]) * ROOT_W'(opb[l][ROOT_W-1:HALF_W]);
				pp_s5[l][3] <= ROOT_W'(opa[l][ROOT_W-1:HALF_W])
					* ROOT_W'(opb[l][ROOT_W-1:HALF_W]);
			end
		end
	end

	// ---------------------------------------------------------------- s6
	logic [RAD_W-1:0] rad2_s6 [2];
	tva_pkg::case_t   case_s6;
	logic             vld_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			case_s6 <= case_s5;
			for (int l = 0; l < 2; l++) begin
				rad2_s6[l] <= RAD_W'(pp_s5[l][0])
					+ (RAD_W'(pp_s5[l][1]) << HALF_W)
					+ (RAD_W'(pp_s5[l][2]) << HALF_W)
					+ (RAD_W'(pp_s5[l][3]) << ROOT_W);
			end
		end
	end

	// u = sqrt(X*Y), v = sqrt(P*Z)
	logic [ROOT_W-1:0] uv [2];
	logic              vld_r2  [ROOT_W];
	tva_pkg::case_t    case_r2 [ROOT_W];

	tva_isqrt #(.LANES(2), .ROOT_W(ROOT_W)) u_quot (
		.clk  (clk),
		.en   (adv),
		.rad  (rad2_s6),
		.root (uv)
	);

	// ---------------------------------------------------------------- s7
	// Leading-one search on max(u, v) to align the larger onto bit 40.
	logic [ROOT_W-1:0]           u_s7, v_s7;
	logic [tva_pkg::SHIFT_W-1:0] k_s7;
	tva_pkg::case_t              case_s7;
	logic                        vld_s7;
	logic [ROOT_W-1:0]           m_max;
	logic [tva_pkg::SHIFT_W-1:0] k_d;

	always_comb begin
		m_max = (uv[0] > uv[1]) ? uv[0] : uv[1];
		k_d   = tva_pkg::SHIFT_W'(tva_pkg::NORM_MSB);
		for (int b = 0; b < ROOT_W; b++) begin
			if (m_max[b]) begin
				k_d = tva_pkg::SHIFT_W'(tva_pkg::NORM_MSB - b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s7    <= uv[0];
			v_s7    <= uv[1];
			k_s7    <= k_d;
			case_s7 <= case_r2[ROOT_W-1];
		end
	end

	// ---------------------------------------------------------------- s8
	logic signed [CX_W-1:0] x_s8, y_s8;
	tva_pkg::case_t         case_s8;
	logic                   vld_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s8    <= $signed(CX_W'(v_s7) << k_s7);
			y_s8    <= $signed(CX_W'(u_s7) << k_s7);
			case_s8 <= case_s7;
		end
	end

	// ---------------------------------------------------------------- CORDIC
	// One vectoring rotation per stage; drive y toward zero, sum angles in z.
	logic signed [CX_W-1:0] cx [ATAN_STEPS];
	logic signed [CX_W-1:0] cy [ATAN_STEPS];
	logic signed [CZ_W-1:0] cz [ATAN_STEPS];
	tva_pkg::case_t         ccase [ATAN_STEPS];
	logic                   cvld  [ATAN_STEPS];

	genvar gi;
	generate
		for (gi = 0; gi < ATAN_STEPS; gi++) begin : g_cordic
			localparam int SH = gi % 64;
			logic signed [CX_W-1:0] xi, yi;
			logic signed [CZ_W-1:0] zi;
			logic signed [CZ_W-1:0] ti;

			always_comb begin
				if (gi == 0) begin
					xi = x_s8;
					yi = y_s8;
					zi = '0;
				end else begin
					xi = cx[(gi == 0) ? 0 : gi-1];
					yi = cy[(gi == 0) ? 0 : gi-1];
					zi = cz[(gi == 0) ? 0 : gi-1];
				end
				ti = $signed(CZ_W'(tva_pkg::atan_tab(5'(gi % 32))));
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					if (!yi[CX_W-1]) begin
						cx[gi] <= xi + (yi >>> SH);
						cy[gi] <= yi - (xi >>> SH);
						cz[gi] <= zi + ti;
					end else begin
						cx[gi] <= xi - (yi >>> SH);
						cy[gi] <= yi + (xi >>> SH);
						cz[gi] <= zi - ti;
					end
					ccase[gi] <= (gi == 0) ? case_s8 : ccase[(gi == 0) ? 0 : gi-1];
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------- valid line
	// Valid bits ride with the data through every stage; all advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int j = 0; j < ROOT_W; j++) begin
				vld_r1[j] <= 1'b0;
				vld_r2[j] <= 1'b0;
			end
			for (int j = 0; j < ATAN_STEPS; j++) begin
				cvld[j] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_r1[0] <= vld_s3;
			for (int j = 1; j < ROOT_W; j++) begin
				vld_r1[j] <= vld_r1[j-1];
			end
			vld_s4 <= vld_r1[ROOT_W-1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_r2[0] <= vld_s6;
			for (int j = 1; j < ROOT_W; j++) begin
				vld_r2[j] <= vld_r2[j-1];
			end
			vld_s7 <= vld_r2[ROOT_W-1];
			vld_s8 <= vld_s7;
			cvld[0] <= vld_s8;
			for (int j = 1; j < ATAN_STEPS; j++) begin
				cvld[j] <= cvld[j-1];
			end
		end
	end

	// Case code rides beside the second root pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			case_r2[0] <= case_s6;
			for (int j = 1; j < ROOT_W; j++) begin
				case_r2[j] <= case_r2[j-1];
			end
		end
	end

	// ---------------------------------------------------------------- output
	// Clamp z at zero, round Q2.30 to Q2.16, clamp at pi; override special cases.
	logic [tva_pkg::ANGLE_W-1:0] angle_q;
	tva_pkg::case_t              case_q;
	logic signed [CZ_W-1:0]      z_fin;
	logic [CZ_W-1:0]             z_rnd;
	logic [tva_pkg::ANGLE_W:0]   ang_w;

	always_comb begin
		z_fin = cz[ATAN_STEPS-1];
		z_rnd = (z_fin[CZ_W-1] ? '0 : CZ_W'(z_fin)) + CZ_W'(1 << (tva_pkg::ROUND_SH - 1));
		ang_w = (tva_pkg::ANGLE_W+1)'(z_rnd >> tva_pkg::ROUND_SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= cvld[ATAN_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case_q <= ccase[ATAN_STEPS-1];
			case (ccase[ATAN_STEPS-1])
				tva_pkg::CASE_COLLAPSED: angle_q <= tva_pkg::ANGLE_PI_3;
				tva_pkg::CASE_FLAT:      angle_q <= tva_pkg::ANGLE_PI;
				default: begin
					if (ang_w > (tva_pkg::ANGLE_W+1)'(tva_pkg::ANGLE_PI)) begin
						angle_q <= tva_pkg::ANGLE_PI;
					end else begin
						angle_q <= ang_w[tva_pkg::ANGLE_W-1:0];
					end
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, angle_q};
	assign m_tuser  = case_q;

	// ---------------------------------------------------------------- checks
	`ASSERT_IMPL(a_collapsed_pi3, clk, arst_n,
		m_tvalid && m_tuser == tva_pkg::CASE_COLLAPSED,
		m_tdata[17:0] == tva_pkg::ANGLE_PI_3, "collapsed case without pi/3")
	`ASSERT_IMPL(a_flat_pi, clk, arst_n,
		m_tvalid && m_tuser == tva_pkg::CASE_FLAT,
		m_tdata[17:0] == tva_pkg::ANGLE_PI, "flat case without pi")
	`ASSERT_IMPL(a_angle_range, clk, arst_n, m_tvalid,
		m_tdata[17:0] <= tva_pkg::ANGLE_PI && m_tuser != 2'd3, "angle or case out of range")
	`ASSERT_CLK(a_hold_on_stall, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
		"output word changed while stalled")
	`ASSERT_CLK(a_ready_follows_out, clk, arst_n,
		s_tready == (!m_tvalid || m_tready), "input ready not tied to output drain")

endmodule
